>>> rtl/wrd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wrd_pkg - shared types and constants for the windowed regression detector
// Sample and register types, ring geometry, window limits and register codes.
// ----------------------------------------------------------------------------
package wrd_pkg;

	localparam int RING_DEPTH = 256;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int MAX_WINDOW = 128;
	localparam int WIN_CAP    = (MAX_WINDOW < RING_DEPTH / 2) ? MAX_WINDOW : RING_DEPTH / 2;

	localparam int SAMPLE_W = 16;
	localparam int WINDOW_W = 8;
	localparam int CFG_W    = 16;
	localparam int CFG_IW   = 2;
	localparam int COUNT_W  = 9;
	localparam int SUM_W    = 24;
	localparam int DIFF_W   = 25;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic        [WINDOW_W-1:0] window_t;
	typedef logic        [CFG_W-1:0]    cfg_data_t;
	typedef logic        [CFG_IW-1:0]   cfg_index_t;
	typedef logic        [RING_AW-1:0]  ring_addr_t;
	typedef logic        [COUNT_W-1:0]  count_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic signed [DIFF_W-1:0]   diff_t;

	localparam cfg_index_t REG_WINDOW    = cfg_index_t'(0);
	localparam cfg_index_t REG_THRESHOLD = cfg_index_t'(1);

	localparam window_t WINDOW_RESET = window_t'(16);
	localparam window_t WINDOW_LIMIT = window_t'(WIN_CAP);

	// Saturate the window register to [1, WINDOW_LIMIT].
	function automatic window_t eff_window(input window_t raw);
		window_t w;
		begin
			w = raw;
			if (w == window_t'(0)) begin
				w = window_t'(1);
			end
			if (w > WINDOW_LIMIT) begin
				w = WINDOW_LIMIT;
			end
			return w;
		end
	endfunction

endpackage
`default_nettype wire

>>> rtl/windowed_regression_detector_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_regression_detector_core - dual moving-average trend comparator
// Stores reward words in a 256-entry ring, keeps exact sums of the last two
// windows and flags when the recent sum minus the prior one falls below threshold*W.
// ----------------------------------------------------------------------------
// Path: a sample word is registered in stage 1, then its result word in the
// output register; a stalled result channel can hold it in stage 1.
// Throughput: one sample word per cycle unless results stall; the ring has
// one write and two read ports, all used in the accept cycle; sums move with stage 1.
// Reset: control state, sums, history count and registers clear at once
// (window = 16, threshold = 0); the sample ring is not cleared.
module windowed_regression_detector_core (
	input  wire                  clk,
	input  wire                  arst_n,
	// configuration write port
	input  wire                  cfg_we,
	input  wrd_pkg::cfg_index_t  cfg_index,
	input  wrd_pkg::cfg_data_t   cfg_data,
	// sample channel
	input  wire                  sample_valid,
	output logic                 sample_stall,
	input  wrd_pkg::sample_t     reward,
	// result channel
	output logic                 result_valid,
	input  wire                  result_stall,
	output logic                 rollback,
	output logic                 history_ready
);
	import wrd_pkg::*;

	// Configuration registers and the precomputed threshold*W product.
	window_t    window_q;
	sample_t    threshold_q;
	diff_t      thr_w_q;

	// History state.
	ring_addr_t wp_q;
	count_t     count_q;
	sum_t       recent_q;
	sum_t       prior_q;

	// Sample ring.
	sample_t    ring [RING_DEPTH];

	// Stage 1: the accepted word plus its two ring reads.
	logic       s1_valid_q;
	sample_t    reward_s1;
	sample_t    moved_s1;
	sample_t    oldest_s1;
	logic       near_s1;
	logic       full_s1;
	logic       ready_s1;

	// Output register.
	logic       out_valid_q;
	logic       rollback_q;
	logic       ready_q;

	window_t    w_eff;
	count_t     w2;
	ring_addr_t addr_moved;
	ring_addr_t addr_oldest;
	count_t     count_nx;
	logic       accept;
	logic       s1_adv;
	logic       s1_fire;
	logic       win_wr;
	sum_t       x_ext;
	sum_t       moved_ext;
	sum_t       oldest_ext;
	sum_t       recent_nx;
	sum_t       prior_nx;
	diff_t      diff;

	// ---------------------------------------------------------------------
	// Handshake: stage 1 moves on when the output register is empty or being
	// drained, and a new sample is taken whenever stage 1 can make room.
	// ---------------------------------------------------------------------
	assign s1_adv       = !out_valid_q || !result_stall;
	assign s1_fire      = s1_valid_q && s1_adv;
	assign sample_stall = s1_valid_q && !s1_adv;
	assign accept       = sample_valid && !sample_stall;
	assign win_wr       = cfg_we && (cfg_index == REG_WINDOW);

	// ---------------------------------------------------------------------
	// Accept-side decisions: window size, read addresses and count update.
	// The word leaving the recent window sits W back, the word leaving the
	// prior window 2W back (the write slot itself when W fills half the ring,
	// read before it is overwritten).
	// ---------------------------------------------------------------------
	assign w_eff       = eff_window(window_q);
	assign w2          = {1'b0, w_eff} << 1;
	assign addr_moved  = wp_q - ring_addr_t'(w_eff);
	assign addr_oldest = wp_q - w2[RING_AW-1:0];
	assign count_nx    = (count_q < w2) ? count_q + count_t'(1) : count_q;

	// ---------------------------------------------------------------------
	// Stage 1 arithmetic: slide both sums and compare their difference with
	// threshold*W, exact at 25 bits.
	// ---------------------------------------------------------------------
	assign x_ext      = sum_t'(reward_s1);
	assign moved_ext  = sum_t'(moved_s1);
	assign oldest_ext = sum_t'(oldest_s1);

	always_comb begin
		recent_nx = recent_q + x_ext;
		prior_nx  = prior_q;
		if (near_s1) begin
			recent_nx = recent_q + x_ext - moved_ext;
			prior_nx  = prior_q + moved_ext;
			if (full_s1) begin
				prior_nx = prior_q + moved_ext - oldest_ext;
			end
		end
	end

	assign diff = diff_t'(recent_nx) - diff_t'(prior_nx);

	// ---------------------------------------------------------------------
	// Ring: write the new word and read both leaving words in the same edge.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			ring[wp_q] <= reward;
			moved_s1   <= ring[addr_moved];
			oldest_s1  <= ring[addr_oldest];
		end
	end

	// Stage 1 payload: hold while stalled.
	always_ff @(posedge clk) begin
		if (accept) begin
			reward_s1 <= reward;
			near_s1   <= ({1'b0, count_q} >= {2'b00, w_eff});
			full_s1   <= (count_q >= w2);
			ready_s1  <= (count_nx >= w2);
		end
	end

	// Output payload: load as stage 1 advances.
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			rollback_q <= ready_s1 && (diff < thr_w_q);
			ready_q    <= ready_s1;
		end
	end

	// ---------------------------------------------------------------------
	// Control state. A window write drops the history; the write pointer
	// keeps running so the ring never needs clearing.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WINDOW_RESET;
			threshold_q <= '0;
			thr_w_q     <= '0;
			wp_q        <= '0;
			count_q     <= '0;
			recent_q    <= '0;
			prior_q     <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			thr_w_q <= diff_t'(threshold_q) * diff_t'({1'b0, w_eff});

			if (win_wr) begin
				window_q <= cfg_data[WINDOW_W-1:0];
			end
			if (cfg_we && (cfg_index == REG_THRESHOLD)) begin
				threshold_q <= cfg_data[SAMPLE_W-1:0];
			end

			if (accept) begin
				wp_q <= wp_q + ring_addr_t'(1);
			end

			if (win_wr) begin
				count_q <= '0;
			end else if (accept) begin
				count_q <= count_nx;
			end

			if (win_wr) begin
				recent_q <= '0;
				prior_q  <= '0;
			end else if (s1_fire) begin
				recent_q <= recent_nx;
				prior_q  <= prior_nx;
			end

			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end

			if (s1_fire) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid  = out_valid_q;
	assign rollback      = rollback_q;
	assign history_ready = ready_q;

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the windowed regression detector
// Streams reward words through the core, predicts every rollback and
// history_ready flag from a local ring and running sums, and compares each
// result word with the oldest prediction. Runs directed edge cases first,
// then random trend segments under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
	import wrd_pkg::*;

	// Register codes that map to nothing in the core; writes must be ignored.
	localparam cfg_index_t REG_SPARE_LO = cfg_index_t'(2);
	localparam cfg_index_t REG_SPARE_HI = cfg_index_t'(3);

	// Cycles with no accepted word on either channel before the run is abandoned.
	localparam int STUCK_LIMIT = 4000;
	// Trailing cycles after the last prediction drains; covers the core latency.
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		logic rollback;
		logic history_ready;
	} verdict_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	cfg_index_t cfg_index;
	cfg_data_t  cfg_data;
	logic       sample_valid;
	logic       sample_stall;
	sample_t    reward;
	logic       result_valid;
	logic       result_stall;
	logic       rollback;
	logic       history_ready;

	windowed_regression_detector_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.reward        (reward),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.rollback      (rollback),
		.history_ready (history_ready)
	);

	// Local copy of the detector state, advanced once per accepted sample word.
	sample_t    trend_ring [RING_DEPTH];
	ring_addr_t trend_wr_ptr;
	int         trend_fill;
	longint     recent_acc;
	longint     prior_acc;
	window_t    window_reg;
	sample_t    threshold_reg;

	// Predicted result words, oldest first.
	verdict_t   pending_verdicts [$];

	int         fail_count;
	int         stuck_cycles;
	int         sender_idle_pct;
	int         receiver_idle_pct;

	// 20-unit clock period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic log_failure(input string what);
		begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("%0t: %s", $time, what);
			end
		end
	endtask

	// Advance the local model by one sample and return the flags it implies.
	function automatic verdict_t predict_trend(input sample_t x);
		int       w;
		sample_t  moved;
		verdict_t v;
		begin
			// Saturate the window to [1, cap]; the register keeps its raw bits.
			w = int'(window_reg);
			if (w < 1) begin
				w = 1;
			end
			if (w > WIN_CAP) begin
				w = WIN_CAP;
			end
			if (trend_fill >= w) begin
				// Oldest recent sample slides into the prior window.
				moved = trend_ring[ring_addr_t'(trend_wr_ptr - w)];
				recent_acc = recent_acc + longint'(x) - longint'(moved);
				prior_acc = prior_acc + longint'(moved);
				if (trend_fill >= 2 * w) begin
					// Oldest prior sample drops out of the prior window.
					prior_acc = prior_acc - longint'(trend_ring[ring_addr_t'(trend_wr_ptr - 2 * w)]);
				end
			end else begin
				recent_acc = recent_acc + longint'(x);
			end
			trend_ring[trend_wr_ptr] = x;
			trend_wr_ptr = trend_wr_ptr + ring_addr_t'(1);
			if (trend_fill < 2 * w) begin
				trend_fill++;
			end
			v.history_ready = (trend_fill >= 2 * w);
			v.rollback = v.history_ready &&
				((recent_acc - prior_acc) < longint'(threshold_reg) * longint'(w));
			return v;
		end
	endfunction

	// Drop valid and hold until every predicted result word has come back.
	task automatic settle_pipeline();
		begin
			sample_valid = 1'b0;
			while (pending_verdicts.size() != 0) begin
				@(posedge clk);
			end
			@(negedge clk);
		end
	endtask

	// Write one register while the core is idle and mirror it in the model.
	task automatic write_reg(input cfg_index_t idx, input cfg_data_t data);
		begin
			settle_pipeline();
			cfg_we    = 1'b1;
			cfg_index = idx;
			cfg_data  = data;
			case (idx)
				REG_WINDOW: begin
					window_reg = data[WINDOW_W-1:0];
					trend_fill = 0;
					recent_acc = 0;
					prior_acc  = 0;
				end
				REG_THRESHOLD: begin
					threshold_reg = sample_t'(data);
				end
				default: begin
				end
			endcase
			@(negedge clk);
			cfg_we   = 1'b0;
			cfg_data = cfg_data_t'($urandom);
		end
	endtask

	// Offer one sample word, idling first at the sender's rate; hold it until taken.
	task automatic send_reward(input sample_t value);
		verdict_t expect_v;
		begin
			while ($urandom_range(0, 99) < sender_idle_pct) begin
				sample_valid = 1'b0;
				reward       = sample_t'($urandom);
				@(negedge clk);
			end
			sample_valid = 1'b1;
			reward       = value;
			do begin
				@(posedge clk);
			end while (sample_stall);
			expect_v = predict_trend(value);
			pending_verdicts = {pending_verdicts, expect_v};
			@(negedge clk);
		end
	endtask

	// Receiver idling: stall the result channel at the chosen rate.
	always @(negedge clk) begin
		result_stall = ($urandom_range(0, 99) < receiver_idle_pct);
	end

	// Compare each accepted result word with the oldest prediction.
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_verdicts.size() == 0) begin
				log_failure($sformatf("unexpected result word: rollback=%0b history_ready=%0b",
					rollback, history_ready));
			end else begin
				want = pending_verdicts.pop_front();
				if (rollback !== want.rollback || history_ready !== want.history_ready) begin
					log_failure($sformatf({"result mismatch: expected rollback=%0b ",
						"history_ready=%0b, got rollback=%0b history_ready=%0b"},
						want.rollback, want.history_ready, rollback, history_ready));
				end
			end
		end
	end

	// Watchdog: abandon the run when no word moves for too long.
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Reset values: window 16 needs 32 samples, so a short burst stays unready.
	task automatic test_reset_defaults();
		begin
			send_reward(sample_t'(32767));
			send_reward(sample_t'(-32768));
			send_reward(sample_t'(0));
			send_reward(sample_t'(1));
			send_reward(sample_t'(-1));
			send_reward(sample_t'(256));
		end
	endtask

	// Window of one: every sample after the first compares two single words.
	task automatic test_single_window_extremes();
		begin
			write_reg(REG_WINDOW, cfg_data_t'(1));
			write_reg(REG_THRESHOLD, cfg_data_t'(0));
			send_reward(sample_t'(32767));
			send_reward(sample_t'(-32768));
			send_reward(sample_t'(-32768));
			send_reward(sample_t'(32767));
			send_reward(sample_t'(0));
			send_reward(sample_t'(0));
		end
	endtask

	// A written zero acts as one; exercise both threshold limits.
	task automatic test_zero_window_threshold_limits();
		begin
			write_reg(REG_WINDOW, cfg_data_t'(0));
			write_reg(REG_THRESHOLD, cfg_data_t'(16'h8000));
			send_reward(sample_t'(-32768));
			send_reward(sample_t'(32767));
			send_reward(sample_t'(-32768));
			// Threshold changes keep the history.
			write_reg(REG_THRESHOLD, cfg_data_t'(16'h7fff));
			send_reward(sample_t'(0));
			send_reward(sample_t'(0));
		end
	endtask

	// Rewriting the same window clears history; unmapped indexes change nothing.
	task automatic test_spare_register_index();
		begin
			write_reg(REG_WINDOW, cfg_data_t'(2));
			write_reg(REG_THRESHOLD, cfg_data_t'(1));
			send_reward(sample_t'(100));
			send_reward(sample_t'(-100));
			send_reward(sample_t'(50));
			send_reward(sample_t'(-50));
			write_reg(REG_WINDOW, cfg_data_t'(2));
			write_reg(REG_SPARE_LO, cfg_data_t'(0));
			write_reg(REG_SPARE_HI, cfg_data_t'($urandom));
			send_reward(sample_t'(-200));
			send_reward(sample_t'(300));
			send_reward(sample_t'(-1));
			send_reward(sample_t'(-300));
			send_reward(sample_t'(400));
		end
	endtask

	// Random segments: one window setting per segment, long enough to fill two
	// windows, with content shaped to produce both rising and falling trends.
	task automatic test_random_trends(input int s_idle, input int r_idle, input int item_goal,
			input window_t first_window);
		int      sent;
		int      seg_len;
		int      style;
		int      weff;
		int      roll;
		int      thr;
		int      slope;
		int      level;
		window_t win;
		sample_t val;
		begin
			sender_idle_pct   = s_idle;
			receiver_idle_pct = r_idle;
			sent = 0;
			win  = first_window;
			while (sent < item_goal) begin
				// Random upper bits: only the low byte belongs to the window.
				write_reg(REG_WINDOW, {8'($urandom), win});
				roll = $urandom_range(0, 9);
				if (roll < 6) begin
					thr = $urandom_range(0, 1023) - 512;
				end else if (roll < 8) begin
					thr = (roll == 6) ? -32768 : 32767;
				end else begin
					thr = int'(sample_t'($urandom));
				end
				write_reg(REG_THRESHOLD, cfg_data_t'(thr));
				if ($urandom_range(0, 9) == 0) begin
					write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI,
						cfg_data_t'($urandom));
				end

				weff = (win == 0) ? 1 : ((int'(win) > WIN_CAP) ? WIN_CAP : int'(win));
				seg_len = 2 * weff + $urandom_range(2, 40);
				style = $urandom_range(0, 3);
				slope = $urandom_range(0, 64) - 32;
				level = $urandom_range(0, 2047) - 1024;
				for (int k = 0; k < seg_len; k++) begin
					case (style)
						0: val = sample_t'($urandom);
						1: val = sample_t'($urandom_range(0, 1023) - 512);
						2: begin
							// Ramp with noise; flip direction now and then.
							if ($urandom_range(0, 31) == 0) begin
								slope = -slope;
							end
							level = level + slope;
							val = sample_t'(level + $urandom_range(0, 63) - 32);
						end
						default: val = ($urandom_range(0, 1) == 0) ? sample_t'(32767)
							: sample_t'(-32768);
					endcase
					// Occasionally move the threshold mid-segment; history is kept.
					if (k == seg_len / 2 && $urandom_range(0, 3) == 0) begin
						write_reg(REG_THRESHOLD, cfg_data_t'($urandom_range(0, 511) - 256));
					end
					send_reward(val);
					sent++;
				end

				// Mostly small windows keep the run short; large ones now and then.
				roll = $urandom_range(0, 19);
				if (roll == 0) begin
					win = window_t'($urandom_range(128, 255));
				end else if (roll == 1) begin
					win = window_t'(0);
				end else if (roll == 2) begin
					win = window_t'(16);
				end else begin
					win = window_t'($urandom_range(1, 12));
				end
			end
		end
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_WINDOW;
		cfg_data     = '0;
		sample_valid = 1'b0;
		reward       = '0;
		result_stall = 1'b0;
		fail_count   = 0;
		stuck_cycles = 0;

		// Model state after reset; the ring is left as is, it is never read unwritten.
		trend_wr_ptr  = '0;
		trend_fill    = 0;
		recent_acc    = 0;
		prior_acc     = 0;
		window_reg    = WINDOW_RESET;
		threshold_reg = '0;

		sender_idle_pct   = 26;
		receiver_idle_pct = 88;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_single_window_extremes();
		test_zero_window_threshold_limits();
		test_spare_register_index();

		test_random_trends(26, 88, 580, window_t'(255));
		test_random_trends(88, 26, 580, window_t'(128));
		test_random_trends(0, 0, 640, window_t'(200));

		// Drain, then give the core a few more cycles to show any stray word.
		settle_pipeline();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_verdicts.size() != 0) begin
			log_failure($sformatf("%0d predicted result words never arrived",
				pending_verdicts.size()));
		end

		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
`default_nettype wire

>>> files.f
rtl/wrd_pkg.sv
rtl/windowed_regression_detector_core.sv
bench/tb_top.sv
